// ===== hdl/sinr_per_user_calculator_defines.svh =====
// Assertion macros for the SINR per user calculator.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef SINR_PER_USER_CALCULATOR_DEFINES_SVH
`define SINR_PER_USER_CALCULATOR_DEFINES_SVH

// check while out of reset
`define SINR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check at every edge, reset included
`define SINR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/sinr_pkg.sv =====
// Shared types and constants for the SINR per user calculator.
// No dependencies.
package sinr_pkg;

    localparam logic [1:0] OP_PWR     = 2'd0;
    localparam logic [1:0] OP_GAIN    = 2'd1;
    localparam logic [1:0] OP_MATRIX  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic CFG_USER_COUNT = 1'b0;
    localparam logic CFG_NOISE      = 1'b1;

    localparam int Q_W = 48;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [31:0] value;
        logic [15:0] tag;
    } t_in;

    typedef struct packed {
        logic [4:0]  user;
        logic [31:0] ratio;
        logic        bad_denominator;
        logic [15:0] tag_out;
    } t_out;

    typedef struct packed {
        logic capture;
        logic issue;
        logic start_noise;
        logic store_noise;
        logic start_ratio;
        logic fin_ok;
        logic fin_bad;
    } t_cmd;

    typedef struct packed {
        logic bad_pre;
        logic n_zero;
        logic sum_last;
        logic pipe_busy;
        logic div_done;
        logic den_bad;
        logic out_busy;
    } t_stat;

endpackage

// ===== hdl/sinr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on sinr_pkg.
module sinr_div
    import sinr_pkg::*;
#(
    parameter int DEN_W = 55
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [Q_W-1:0]   i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [DEN_W-1:0] r_dvs;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[Q_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/sinr_dp.sv =====
// Datapath: stores, multiply-accumulate pipeline, divider and result register.
// Depends on sinr_pkg and sinr_div.
module sinr_dp
    import sinr_pkg::*;
#(
    parameter int MAX_USERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in         i_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_valid,
    output t_out        o_out
);

    localparam int AW    = $clog2(MAX_USERS);
    localparam int JW    = $clog2(MAX_USERS + 1);
    localparam int MW    = $clog2(MAX_USERS * MAX_USERS);
    localparam int SUM_W = Q_W + JW;
    localparam int DEN_W = SUM_W + 1;

    logic [31:0] r_pwr_mem [MAX_USERS];
    logic [31:0] r_tg_mem  [MAX_USERS];
    logic [31:0] r_gm_mem  [MAX_USERS*MAX_USERS];

    logic [5:0]       r_uc;
    logic [31:0]      r_noise;
    logic [4:0]       r_row;
    logic [15:0]      r_tag;
    logic             r_row_ok;
    logic [JW-1:0]    r_j;
    logic [31:0]      r_pwr_rd;
    logic [31:0]      r_tg_rd;
    logic [31:0]      r_gm_rd;
    logic             r_v1;
    logic             r_v2;
    logic [Q_W-1:0]   r_prod;
    logic [SUM_W-1:0] r_sum;
    logic [31:0]      r_pw;
    logic [31:0]      r_gain;
    logic [Q_W-1:0]   r_nterm;
    logic             r_ovld;
    t_out             r_out;

    logic             in_row_ok;
    logic             in_col_ok;
    logic [AW-1:0]    in_row_idx;
    logic [MW-1:0]    wr_addr;
    logic [MW-1:0]    rd_addr;
    logic [AW-1:0]    pwr_addr;
    logic [JW-1:0]    n_users;
    logic [63:0]      prod_full;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] den_net;
    logic             div_start;
    logic [Q_W-1:0]   div_dividend;
    logic [DEN_W-1:0] div_divisor;
    logic             div_done;
    logic [Q_W-1:0]   div_q;

    always_comb begin
        in_row_ok  = 32'(i_in.row) < MAX_USERS;
        in_col_ok  = 32'(i_in.col) < MAX_USERS;
        in_row_idx = AW'(i_in.row);
        wr_addr    = MW'(in_row_idx) * MW'(MAX_USERS) + MW'(AW'(i_in.col));
        rd_addr    = MW'(AW'(r_row)) * MW'(MAX_USERS) + MW'(r_j[AW-1:0]);
        pwr_addr   = i_cmd.issue ? r_j[AW-1:0] : in_row_idx;
        n_users    = (32'(r_uc) > MAX_USERS) ? JW'(MAX_USERS) : JW'(r_uc);
        prod_full  = r_gm_rd * r_pwr_rd;
        den        = DEN_W'(r_sum) + DEN_W'(r_nterm);
        den_net    = den - DEN_W'(r_pw);
        div_start  = i_cmd.start_noise | i_cmd.start_ratio;
        if (i_cmd.start_noise) begin
            div_dividend = {r_noise, 16'h0};
            div_divisor  = DEN_W'(r_gain);
        end else begin
            div_dividend = {r_pw, 16'h0};
            div_divisor  = den_net;
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_accept && i_in.op == OP_PWR && in_row_ok) begin
            r_pwr_mem[in_row_idx] <= i_in.value;
        end
        r_pwr_rd <= r_pwr_mem[pwr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_in.op == OP_GAIN && in_row_ok) begin
            r_tg_mem[in_row_idx] <= i_in.value;
        end
        r_tg_rd <= r_tg_mem[in_row_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_in.op == OP_MATRIX && in_row_ok && in_col_ok) begin
            r_gm_mem[wr_addr] <= i_in.value;
        end
        r_gm_rd <= r_gm_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uc    <= 6'd32;
            r_noise <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ovld  <= 1'b0;
            r_j     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USER_COUNT: r_uc    <= i_cfg_data[5:0];
                    CFG_NOISE:      r_noise <= i_cfg_data;
                    default: ;
                endcase
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_accept) begin
                r_j <= '0;
            end else if (i_cmd.issue) begin
                r_j <= r_j + JW'(1);
            end
            if (i_cmd.fin_ok || i_cmd.fin_bad) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_row    <= i_in.row;
            r_tag    <= i_in.tag;
            r_row_ok <= in_row_ok;
            r_sum    <= '0;
        end else if (r_v2) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
        r_prod <= prod_full[63:16];
        if (i_cmd.capture) begin
            r_pw   <= r_pwr_rd;
            r_gain <= r_tg_rd;
        end
        if (i_cmd.store_noise) begin
            r_nterm <= div_q;
        end
        if (i_cmd.fin_ok || i_cmd.fin_bad) begin
            r_out.user            <= r_row;
            r_out.tag_out         <= r_tag;
            r_out.bad_denominator <= i_cmd.fin_bad;
            if (i_cmd.fin_bad) begin
                r_out.ratio <= '0;
            end else if (div_q[Q_W-1:32] != '0) begin
                r_out.ratio <= '1;
            end else begin
                r_out.ratio <= div_q[31:0];
            end
        end
    end

    sinr_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        o_stat.bad_pre   = !r_row_ok || r_tg_rd == '0;
        o_stat.n_zero    = n_users == '0;
        o_stat.sum_last  = (r_j + JW'(1)) == n_users;
        o_stat.pipe_busy = r_v1 | r_v2;
        o_stat.div_done  = div_done;
        o_stat.den_bad   = den <= DEN_W'(r_pw);
        o_stat.out_busy  = r_ovld & !i_out_ready;
    end

    assign o_valid = r_ovld;
    assign o_out   = r_out;

endmodule

// ===== hdl/sinr_ctrl.sv =====
// Controller: sequences lookup, weighted sum, up to two divisions and result load.
// Depends on sinr_pkg.
module sinr_ctrl
    import sinr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  logic  i_compute,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_ready
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_DRAIN = 10'b0000001000,
        S_NDIV  = 10'b0000010000,
        S_DCHK  = 10'b0000100000,
        S_RDIV  = 10'b0001000000,
        S_FOK   = 10'b0010000000,
        S_FBAD  = 10'b0100000000,
        S_SPARE = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept && i_compute) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.capture = 1'b1;
                if (i_stat.bad_pre) begin
                    n_state = S_FBAD;
                end else if (i_stat.n_zero) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.issue = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.start_noise = 1'b1;
                    n_state = S_NDIV;
                end
            end
            S_NDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.store_noise = 1'b1;
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (i_stat.den_bad) begin
                    n_state = S_FBAD;
                end else begin
                    o_cmd.start_ratio = 1'b1;
                    n_state = S_RDIV;
                end
            end
            S_RDIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FOK;
                end
            end
            S_FOK: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin_ok = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FBAD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin_bad = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = r_state == S_IDLE;

endmodule

// ===== hdl/sinr_per_user_calculator.sv =====
// SINR per user calculator: a load is written to its store at its transfer; a compute walks the
// n active matrix entries (n = active users, up to MAX_USERS) one entry per cycle, then runs the
// bit-serial 48-bit divider up to twice, for the noise term and for the ratio, before result valid.
// One item in flight; a waiting result does not block loads.
// Synchronous active-low reset clears control and config registers, not stores or data registers.
`include "sinr_per_user_calculator_defines.svh"
module sinr_per_user_calculator
    import sinr_pkg::*;
#(
    parameter int MAX_USERS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic  accept;
    t_cmd  cmd;
    t_stat stat;

    assign accept = i_in_valid & o_in_ready;

    sinr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_compute (i_in_data.op == OP_COMPUTE),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_ready   (o_in_ready)
    );

    sinr_dp #(
        .MAX_USERS (MAX_USERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_out       (o_out_data)
    );

    `SINR_ASSERT(a_busy_after_compute, (accept && i_in_data.op == OP_COMPUTE) |=> !o_in_ready, "compute transfer did not make block busy")
    `SINR_ASSERT(a_bad_zero_ratio, (o_out_valid && o_out_data.bad_denominator) |-> o_out_data.ratio == '0, "flagged result has nonzero ratio")
    `SINR_ASSERT_ALWAYS(a_reset_no_output, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

// ===== tb/sv/sinr_per_user_calculator_checker.sv =====
// Checker for the SINR per user calculator: watches the input, output and register ports,
// predicts each compute result and compares it field by field. Depends on sinr_pkg.
module sinr_per_user_calculator_checker
    import sinr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_USERS = 32;

    logic [5:0]  active_users;
    logic [31:0] noise_level;
    logic [31:0] tx_power [NUM_USERS];
    logic [31:0] target_gain [NUM_USERS];
    logic [31:0] cross_gain [NUM_USERS][NUM_USERS];
    t_out        sinr_expected[$];

    function automatic t_out predict_sinr(input t_in it);
        t_out        res;
        int          n;
        logic [63:0] acc;
        logic [63:0] noise_term;
        logic [63:0] denom;
        logic [63:0] quot;
        res.user = it.row;
        res.tag_out = it.tag;
        res.ratio = '0;
        res.bad_denominator = 1'b1;
        if (target_gain[it.row] != 0) begin
            n = (active_users > NUM_USERS) ? NUM_USERS : int'(active_users);
            acc = '0;
            for (int j = 0; j < n; j++) begin
                acc += (64'(cross_gain[it.row][j]) * 64'(tx_power[j])) >> 16;
            end
            noise_term = {16'd0, noise_level, 16'd0} / 64'(target_gain[it.row]);
            denom = acc + noise_term;
            if (denom > 64'(tx_power[it.row])) begin
                denom -= 64'(tx_power[it.row]);
                quot = {16'd0, tx_power[it.row], 16'd0} / denom;
                res.ratio = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                res.bad_denominator = 1'b0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            active_users <= 6'd32;
            noise_level <= '0;
            sinr_expected.delete();
            o_errors <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_USER_COUNT) begin
                    active_users <= i_cfg_data[5:0];
                end else begin
                    noise_level <= i_cfg_data;
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.op)
                    OP_PWR:     tx_power[i_in_data.row] = i_in_data.value;
                    OP_GAIN:    target_gain[i_in_data.row] = i_in_data.value;
                    OP_MATRIX:  cross_gain[i_in_data.row][i_in_data.col] = i_in_data.value;
                    OP_COMPUTE: sinr_expected.push_back(predict_sinr(i_in_data));
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (sinr_expected.size() == 0) begin
                    $error("result with no compute pending: user %0d", i_out_data.user);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = sinr_expected.pop_front();
                    o_checked <= o_checked + 1;
                    if (exp_r != i_out_data) begin
                        o_errors <= o_errors + 1;
                        if (exp_r.user != i_out_data.user)
                            $error("user: expected %0d got %0d", exp_r.user, i_out_data.user);
                        if (exp_r.ratio != i_out_data.ratio)
                            $error("ratio: expected %h got %h", exp_r.ratio, i_out_data.ratio);
                        if (exp_r.bad_denominator != i_out_data.bad_denominator)
                            $error("bad_denominator: expected %0d got %0d",
                                exp_r.bad_denominator, i_out_data.bad_denominator);
                        if (exp_r.tag_out != i_out_data.tag_out)
                            $error("tag_out: expected %h got %h",
                                exp_r.tag_out, i_out_data.tag_out);
                    end
                end
            end
        end
        o_pending <= sinr_expected.size();
    end
endmodule

// ===== tb/sv/sinr_per_user_calculator_test.sv =====
// Testbench top for the SINR per user calculator: clock, reset, stimulus and verdict.
// Depends on sinr_pkg, the block and sinr_per_user_calculator_checker.
module sinr_per_user_calculator_test;
    import sinr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_USER_COUNT;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          checked;
    bit          stall_on = 1'b1;
    int          idle_cycles = 0;
    int          configs_run = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sinr_per_user_calculator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    sinr_per_user_calculator_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always @(negedge i_clk) begin
        out_ready <= stall_on ? ($urandom_range(99) >= 18) : 1'b1;
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(input logic [1:0] op, input logic [4:0] row, input logic [4:0] col,
                        input logic [31:0] value, input logic [15:0] tag);
        t_in it;
        it.op = op;
        it.row = row;
        it.col = col;
        it.value = value;
        it.tag = tag;
        @(negedge i_clk);
        while (stall_on && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!(in_valid && in_ready));
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'($urandom);
            4:       return 32'($urandom_range(32'h0000_4000, 32'h0004_0000));
            default: return 32'($urandom_range(32'h0000_0100, 32'h0002_0000));
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [1:0] op;
        for (int k = 0; k < count; k++) begin
            op = ($urandom_range(99) < 35) ? OP_COMPUTE : 2'($urandom_range(2));
            send(op, 5'($urandom), 5'($urandom), pick_value(), 16'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every store so no compute reads an unwritten entry
        for (int r = 0; r < 32; r++) begin
            send(OP_PWR, 5'(r), 5'($urandom), 32'($urandom_range(32'h100, 32'h3_0000)),
                16'($urandom));
            send(OP_GAIN, 5'(r), 5'($urandom), 32'($urandom_range(32'h100, 32'h3_0000)),
                16'($urandom));
            for (int c = 0; c < 32; c++) begin
                send(OP_MATRIX, 5'(r), 5'(c),
                    (r == 1 || r == 2) ? 32'd0 : 32'($urandom_range(0, 32'h2_0000)),
                    16'($urandom));
            end
        end

        send(OP_MATRIX, 5'd1, 5'd1, 32'h0001_0001, 16'h0000);
        send(OP_PWR, 5'd1, 5'd0, 32'hFFFF_FFFF, 16'h0000);
        send(OP_COMPUTE, 5'd1, 5'd31, 32'hFFFF_FFFF, 16'h0000);
        send(OP_COMPUTE, 5'd2, 5'd0, 32'd0, 16'hFFFF);
        send(OP_GAIN, 5'd3, 5'd0, 32'd0, 16'h1234);
        send(OP_COMPUTE, 5'd3, 5'd0, 32'd0, 16'h1234);
        send(OP_PWR, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_GAIN, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_MATRIX, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_COMPUTE, 5'd31, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send(OP_COMPUTE, 5'd0, 5'd0, 32'd0, 16'h8000);
        send(OP_PWR, 5'd0, 5'd0, 32'd0, 16'h0001);
        send(OP_COMPUTE, 5'd0, 5'd0, 32'd0, 16'h0001);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_USER_COUNT, 32'd1);
                    write_reg(CFG_NOISE, 32'd0);
                end
                1: begin
                    write_reg(CFG_USER_COUNT, 32'd32);
                    write_reg(CFG_NOISE, 32'hFFFF_FFFF);
                end
                2: begin
                    write_reg(CFG_USER_COUNT, 32'd0);
                    write_reg(CFG_NOISE, 32'($urandom_range(32'h10, 32'h2_0000)));
                end
                3: begin
                    write_reg(CFG_USER_COUNT, 32'd63);
                    write_reg(CFG_NOISE, 32'($urandom));
                end
                default: begin
                    write_reg(CFG_USER_COUNT, 32'($urandom_range(1, 32)));
                    write_reg(CFG_NOISE, 32'($urandom_range(0, 32'h1_0000)));
                end
            endcase
            configs_run++;
            stall_on = (ph != 3);
            random_phase(140);
            drain();
        end

        $display("ran %0d register settings; %0d compute results checked", configs_run, checked);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sinr_pkg.sv
hdl/sinr_div.sv
hdl/sinr_dp.sv
hdl/sinr_ctrl.sv
hdl/sinr_per_user_calculator.sv
tb/sv/sinr_per_user_calculator_checker.sv
tb/sv/sinr_per_user_calculator_test.sv
